// ===== rtl/apc_pkg.sv =====
// apc_pkg: shared types for the amicable pair checker.
// Controller state encoding and the command/status bundles between the
// controller (apc_ctrl) and the datapath (apc_datapath).
`timescale 1ns / 1ps
`default_nettype none
package apc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STEP,
    ST_EVAL1,
    ST_CHECK,
    ST_EVAL2,
    ST_OUTPUT
  } apc_state_t;

  typedef struct packed {
    logic load_n;     // capture candidate, start first aliquot pass
    logic load_s;     // start second aliquot pass on first sum
    logic div_step;   // one restoring division step
    logic acc_step;   // accumulate divisor pair, advance trial divisor
    logic eval1;      // latch first aliquot sum
    logic eval2;      // compare second aliquot sum with candidate
    logic write_out;  // load result register
  } apc_cmd_t;

  typedef struct packed {
    logic div_last;   // current division step is the last one
    logic loop_done;  // quotient below divisor: trial division finished
    logic need_pass2; // first sum qualifies for the second pass
    logic out_free;   // result register can take a new result
  } apc_status_t;

endpackage
`default_nettype wire

// ===== rtl/amicable_pair_checker_unit.sv =====
// Amicable pair checker: one candidate in, partner / pair flag / ordinal out.
// Each pass tries divisors d while n/d >= d, up to isqrt(n); a second pass on the first sum
// s (the partner) runs only when s qualifies; both passes share one bit-serial restoring divider.
// Throughput: one candidate at a time; in_ready returns the cycle after the result is loaded
// into the output register, which holds it until transferred and stalls the next load.
// Reset (rst_n low, synchronous): idle, output empty, pair ordinal back to 1.
`timescale 1ns / 1ps
`default_nettype none
module amicable_pair_checker_unit #(
  parameter int NUMBER_WIDTH = 20,
  parameter int SUM_WIDTH    = 24,
  parameter int COUNT_WIDTH  = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [NUMBER_WIDTH-1:0] in_candidate,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [SUM_WIDTH-1:0]    out_partner,
  output logic                    out_is_pair,
  output logic [COUNT_WIDTH-1:0]  out_pair_ordinal
);
  import apc_pkg::*;

  apc_cmd_t    cmd;
  apc_status_t status;

  apc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  apc_datapath #(
    .NUMBER_WIDTH (NUMBER_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_candidate     (in_candidate),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_partner      (out_partner),
    .out_is_pair      (out_is_pair),
    .out_pair_ordinal (out_pair_ordinal)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_out |-> status.out_free)
    else $error("result register overwritten before transfer");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_n, cmd.load_s, cmd.div_step, cmd.acc_step,
              cmd.eval1, cmd.eval2, cmd.write_out}))
    else $error("conflicting datapath commands");

  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second candidate taken while busy");

  a_ordinal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_pair) |-> (out_pair_ordinal == '0))
    else $error("nonzero ordinal on a non-pair result");

endmodule
`default_nettype wire

// ===== rtl/apc_datapath.sv =====
// apc_datapath: operand, trial divisor, bit-serial restoring divider,
// accumulator, pair ordinal counter and result register.
// Depends on apc_pkg for the command/status bundles.
`timescale 1ns / 1ps
`default_nettype none
module apc_datapath #(
  parameter int NUMBER_WIDTH = 20,
  parameter int SUM_WIDTH    = 24,
  parameter int COUNT_WIDTH  = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  apc_pkg::apc_cmd_t       cmd,
  output apc_pkg::apc_status_t    status,
  input  wire  [NUMBER_WIDTH-1:0] in_candidate,
  input  wire                     out_ready,
  output logic                    out_valid,
  output logic [SUM_WIDTH-1:0]    out_partner,
  output logic                    out_is_pair,
  output logic [COUNT_WIDTH-1:0]  out_pair_ordinal
);
  import apc_pkg::*;

  localparam int VAL_W = (NUMBER_WIDTH > SUM_WIDTH) ? NUMBER_WIDTH : SUM_WIDTH;
  localparam int ACC_W = VAL_W + 3;
  localparam int CNT_W = $clog2(VAL_W);

  logic [NUMBER_WIDTH-1:0] n_r;
  logic [VAL_W-1:0]        m_r;
  logic [VAL_W-1:0]        d_r;
  logic [VAL_W-1:0]        rem_r;
  logic [VAL_W-1:0]        quo_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [ACC_W-1:0]        acc_r;
  logic [ACC_W-1:0]        s1_r;
  logic                    hit_r;
  logic                    out_valid_r;
  logic [SUM_WIDTH-1:0]    out_partner_r;
  logic                    out_is_pair_r;
  logic [COUNT_WIDTH-1:0]  out_ordinal_r;
  logic [COUNT_WIDTH-1:0]  next_ord_r;

  logic [VAL_W:0]   shifted;
  logic [VAL_W:0]   trial;
  logic             fits;
  logic [VAL_W-1:0] rem_nxt;
  logic [VAL_W-1:0] quo_nxt;
  logic [ACC_W-1:0] addend;
  logic [ACC_W-1:0] aliq;
  logic             s1_big;
  logic [VAL_W-1:0] s1_val;

  // restoring division step
  assign shifted = {rem_r, quo_r[VAL_W-1]};
  assign trial   = shifted - {1'b0, d_r};
  assign fits    = ~trial[VAL_W];
  assign rem_nxt = fits ? trial[VAL_W-1:0] : shifted[VAL_W-1:0];
  assign quo_nxt = {quo_r[VAL_W-2:0], fits};

  assign addend = (rem_r == '0) ?
                  (ACC_W'(d_r) + ((quo_r != d_r) ? ACC_W'(quo_r) : '0)) : '0;
  assign aliq   = acc_r - ACC_W'(m_r);
  assign s1_big = (s1_r[ACC_W-1:SUM_WIDTH] != '0);
  assign s1_val = VAL_W'(s1_r[SUM_WIDTH-1:0]);

  assign status.div_last   = (cnt_r == CNT_W'(VAL_W - 1));
  assign status.loop_done  = (quo_r < d_r);
  assign status.need_pass2 = !s1_big && (n_r != '0) && (ACC_W'(n_r) <= s1_r);
  assign status.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_n) begin
      n_r   <= in_candidate;
      m_r   <= VAL_W'(in_candidate);
      quo_r <= VAL_W'(in_candidate);
      rem_r <= '0;
      cnt_r <= '0;
      acc_r <= '0;
      d_r   <= VAL_W'(1);
      hit_r <= 1'b0;
    end else if (cmd.load_s) begin
      m_r   <= s1_val;
      quo_r <= s1_val;
      rem_r <= '0;
      cnt_r <= '0;
      acc_r <= '0;
      d_r   <= VAL_W'(1);
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (cmd.acc_step) begin
      acc_r <= acc_r + addend;
      d_r   <= d_r + VAL_W'(1);
      quo_r <= m_r;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.eval1) begin
      s1_r <= aliq;
    end
    if (cmd.eval2) begin
      hit_r <= (aliq == ACC_W'(n_r));
    end
    if (cmd.write_out) begin
      out_partner_r <= s1_big ? '1 : s1_r[SUM_WIDTH-1:0];
      out_is_pair_r <= hit_r;
      out_ordinal_r <= hit_r ? next_ord_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      next_ord_r  <= COUNT_WIDTH'(1);
    end else begin
      if (cmd.write_out) begin
        out_valid_r <= 1'b1;
        if (hit_r) begin
          next_ord_r <= next_ord_r + COUNT_WIDTH'(1);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_partner      = out_partner_r;
  assign out_is_pair      = out_is_pair_r;
  assign out_pair_ordinal = out_ordinal_r;

endmodule
`default_nettype wire

// ===== rtl/apc_ctrl.sv =====
// apc_ctrl: sequencer for the two trial-division passes and result handoff.
// Depends on apc_pkg for state encoding and command/status bundles.
`timescale 1ns / 1ps
`default_nettype none
module apc_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  apc_pkg::apc_status_t status,
  output apc_pkg::apc_cmd_t    cmd
);
  import apc_pkg::*;

  apc_state_t state_r, state_nxt;
  logic       pass2_r, pass2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass2_r <= pass2_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pass2_nxt = pass2_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_n = 1'b1;
          pass2_nxt  = 1'b0;
          state_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (status.loop_done) begin
          state_nxt = pass2_r ? ST_EVAL2 : ST_EVAL1;
        end else begin
          cmd.acc_step = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_EVAL1: begin
        cmd.eval1 = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.need_pass2) begin
          cmd.load_s = 1'b1;
          pass2_nxt  = 1'b1;
          state_nxt  = ST_DIV;
        end else begin
          state_nxt = ST_OUTPUT;
        end
      end
      ST_EVAL2: begin
        cmd.eval2 = 1'b1;
        state_nxt = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (status.out_free) begin
          cmd.write_out = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for amicable_pair_checker_unit: landmark candidates, then random ones.
// A scoreboard class predicts partner, pair flag and ordinal for every transfer.
// Depends on rtl/amicable_pair_checker_unit.sv.
`timescale 1ns / 1ps
module testbench;

  localparam int NUMBER_WIDTH = 20;
  localparam int SUM_WIDTH    = 24;
  localparam int COUNT_WIDTH  = 16;
  localparam longint unsigned SUM_MAX = (64'd1 << SUM_WIDTH) - 1;

  typedef struct packed {
    logic [SUM_WIDTH-1:0]   partner;
    logic                   is_pair;
    logic [COUNT_WIDTH-1:0] ordinal;
  } verdict_t;

  class pair_tally;
    verdict_t               pending_verdicts[$];
    logic [COUNT_WIDTH-1:0] next_ordinal;
    int                     errors;
    int                     candidates;
    int                     hits;

    function new();
      next_ordinal = COUNT_WIDTH'(1);
      errors = 0;
      candidates = 0;
      hits = 0;
    endfunction

    function longint unsigned aliquot_of(input longint unsigned n);
      longint unsigned total;
      longint unsigned d;
      if (n < 2) return 0;
      total = 0;
      for (d = 1; d * d <= n; d++) begin
        if (n % d == 0) begin
          total += d;
          if (n / d != d) total += n / d;
        end
      end
      return total - n;
    endfunction

    function void note_candidate(input logic [NUMBER_WIDTH-1:0] n);
      longint unsigned first_sum;
      longint unsigned nv;
      verdict_t v;
      nv = 64'(n);
      first_sum = aliquot_of(nv);
      v = '0;
      if (first_sum > SUM_MAX) begin
        v.partner = '1;
      end else begin
        v.partner = first_sum[SUM_WIDTH-1:0];
        if (nv != 0 && nv <= first_sum && aliquot_of(first_sum) == nv) begin
          v.is_pair = 1'b1;
          v.ordinal = next_ordinal;
          next_ordinal = next_ordinal + 1'b1;
          hits++;
        end
      end
      pending_verdicts.push_back(v);
      candidates++;
    endfunction

    function void check_result(input logic [SUM_WIDTH-1:0] partner, input logic is_pair,
                               input logic [COUNT_WIDTH-1:0] ordinal);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, partner %0d", $time, partner);
        return;
      end
      want = pending_verdicts.pop_front();
      if (partner !== want.partner) begin
        errors++;
        $display("%0t: partner expected %0d actual %0d", $time, want.partner, partner);
      end
      if (is_pair !== want.is_pair) begin
        errors++;
        $display("%0t: is_pair expected %0b actual %0b", $time, want.is_pair, is_pair);
      end
      if (ordinal !== want.ordinal) begin
        errors++;
        $display("%0t: pair_ordinal expected %0d actual %0d", $time, want.ordinal, ordinal);
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [NUMBER_WIDTH-1:0] in_candidate;
  logic                    out_valid;
  logic                    out_ready;
  logic [SUM_WIDTH-1:0]    out_partner;
  logic                    out_is_pair;
  logic [COUNT_WIDTH-1:0]  out_pair_ordinal;

  pair_tally book;

  amicable_pair_checker_unit #(
    .NUMBER_WIDTH(NUMBER_WIDTH),
    .SUM_WIDTH   (SUM_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_candidate    (in_candidate),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_partner     (out_partner),
    .out_is_pair     (out_is_pair),
    .out_pair_ordinal(out_pair_ordinal)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #360_000_000;
    $display("simulation failed");
    $finish;
  end

  // zero, one, perfects, pair members on both sides, powers of two, all ones
  function automatic logic [NUMBER_WIDTH-1:0] landmark(input int idx);
    case (idx)
      0:  return 20'd0;
      1:  return 20'd1;
      2:  return 20'd2;
      3:  return 20'd3;
      4:  return 20'd4;
      5:  return 20'd6;
      6:  return 20'd12;
      7:  return 20'd28;
      8:  return 20'd220;
      9:  return 20'd284;
      10: return 20'd496;
      11: return 20'd1184;
      12: return 20'd1210;
      13: return 20'd8128;
      14: return 20'd12285;
      15: return 20'd14595;
      16: return 20'd66928;
      17: return 20'd66992;
      18: return 20'd524288;
      19: return 20'd947835;
      20: return 20'd998104;
      default: return 20'hFFFFF;
    endcase
  endfunction

  function automatic logic [NUMBER_WIDTH-1:0] known_member(input int idx);
    case (idx)
      0:  return 20'd6;
      1:  return 20'd28;
      2:  return 20'd496;
      3:  return 20'd8128;
      4:  return 20'd220;
      5:  return 20'd284;
      6:  return 20'd1184;
      7:  return 20'd1210;
      8:  return 20'd2620;
      9:  return 20'd2924;
      10: return 20'd5020;
      11: return 20'd5564;
      12: return 20'd6232;
      13: return 20'd6368;
      14: return 20'd10744;
      15: return 20'd10856;
      16: return 20'd17296;
      17: return 20'd18416;
      18: return 20'd63020;
      default: return 20'd76084;
    endcase
  endfunction

  task automatic send_candidate(input logic [NUMBER_WIDTH-1:0] value, input bit steady);
    while (!steady && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_candidate <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_candidate(value);
  endtask

  initial begin : result_sink
    int  received_count;
    bit  held;
    received_count = 0;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        book.check_result(out_partner, out_is_pair, out_pair_ordinal);
        received_count++;
      end
      if (!held && received_count == 30) begin
        // long stall so the unit fills and backs up its input
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (5000) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= (received_count >= 60 && received_count < 85) ||
                     $urandom_range(99) >= 11;
      end
    end
  end

  initial begin : stimulus
    int                      k;
    int                      draw;
    logic [NUMBER_WIDTH-1:0] pick;
    book = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_candidate <= '0;
    out_ready <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < 22; k++) send_candidate(landmark(k), 1'b0);

    // mostly small numbers to keep the divider loops short, a few full width
    for (k = 0; k < 78; k++) begin
      draw = $urandom_range(99);
      if (draw < 60)      pick = NUMBER_WIDTH'($urandom_range(2000));
      else if (draw < 72) pick = known_member($urandom_range(19));
      else if (draw < 80) pick = NUMBER_WIDTH'($urandom_range(15));
      else if (draw < 96) pick = NUMBER_WIDTH'($urandom_range(30000));
      else                pick = NUMBER_WIDTH'($urandom());
      send_candidate(pick, k >= 30 && k < 55);
    end
    in_valid <= 1'b0;

    while (book.pending_verdicts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("%0d candidates checked against both aliquot passes, %0d flagged as pairs",
             book.candidates, book.hits);
    $display("covered zero, one, perfects, pair members, full-width values and a long stall");
    if (book.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
